### hdl/hidkt_pkg.sv
// Shared types, HID usage constants and the character-to-key lookup for the
// ASCII to HID key typer. No dependencies.

package hidkt_pkg;

   localparam logic [7:0] MOD_LSHIFT  = 8'h02;
   localparam logic [7:0] MOD_NONE    = 8'h00;
   localparam logic [7:0] USAGE_NONE  = 8'd0;
   localparam logic [7:0] USAGE_A     = 8'd4;
   localparam logic [7:0] USAGE_ENTER = 8'd40;
   localparam logic [7:0] USAGE_TAB   = 8'd43;
   localparam logic [7:0] USAGE_SPACE = 8'd44;
   localparam logic [7:0] USAGE_MINUS = 8'd45;
   localparam logic [7:0] USAGE_EQUAL = 8'd46;

   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_PUNCT_LO   = 8'h20;
   localparam logic [7:0] CHAR_PUNCT_HI   = 8'h40;
   localparam logic [7:0] CHAR_UPPER_LO   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_HI   = 8'h5A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_LO   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_HI   = 8'h7A;

   localparam int PUNCT_COUNT = 33;

   // US layout, space through at-sign
   localparam logic [7:0] PUNCT_KEY [PUNCT_COUNT] = '{
      USAGE_SPACE, 8'd30, 8'd0,  8'd32, 8'd33, 8'd34, 8'd36, 8'd0,
      8'd38, 8'd39, 8'd37, USAGE_EQUAL, 8'd54, USAGE_MINUS, 8'd55, 8'd0,
      8'd39, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36,
      8'd37, 8'd38, 8'd51, 8'd51, 8'd54, USAGE_EQUAL, 8'd55, 8'd0,
      8'd31
   };
   localparam logic PUNCT_SHIFT [PUNCT_COUNT] = '{
      1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
      1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
      1'b1
   };

   typedef struct packed {
      logic [7:0] modifier;
      logic [7:0] key;
   } key_report_type;

   function automatic key_report_type map_char(input logic [7:0] c);
      key_report_type r;
      logic [7:0]     ofs;
      r.modifier = MOD_NONE;
      r.key      = USAGE_NONE;
      ofs        = 8'h00;
      if (c >= CHAR_PUNCT_LO && c <= CHAR_PUNCT_HI) begin
         ofs        = c - CHAR_PUNCT_LO;
         r.key      = PUNCT_KEY[ofs[5:0]];
         r.modifier = PUNCT_SHIFT[ofs[5:0]] ? MOD_LSHIFT : MOD_NONE;
      end else if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
         r.modifier = MOD_LSHIFT;
         r.key      = USAGE_A + (c - CHAR_UPPER_LO);
      end else if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) begin
         r.key = USAGE_A + (c - CHAR_LOWER_LO);
      end else if (c == CHAR_NEWLINE) begin
         r.key = USAGE_ENTER;
      end else if (c == CHAR_TAB) begin
         r.key = USAGE_TAB;
      end else if (c == CHAR_UNDERSCORE) begin
         r.modifier = MOD_LSHIFT;
         r.key      = USAGE_MINUS;
      end
      return r;
   endfunction

endpackage

### hdl/hidkt_if.sv
// Valid/ready channel interfaces for the key typer: characters in,
// HID reports out. No dependencies.

interface hidkt_char_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface hidkt_report_if;
   logic       valid;
   logic       ready;
   logic [7:0] modifier_byte;
   logic [7:0] key_usage;
   logic       last_of_run;

   modport source (output valid, output modifier_byte, output key_usage,
                   output last_of_run, input ready);
   modport sink   (input valid, input modifier_byte, input key_usage,
                   input last_of_run, output ready);
endinterface

### hdl/ascii_to_hid_key_typer.sv
// ASCII to USB HID keyboard report converter, top level.
// Depends on hidkt_pkg and the channel interfaces in hidkt_if.sv.

// One character per item in, one or two HID reports (modifier, key usage,
// last_of_run) out. Characters are captured in an input register and mapped
// to a report on their way into the output register, so a new character is
// taken every cycle unless the output stalls or a release is inserted. A
// character whose key repeats the previous nonzero key first emits a release
// report (0, 0, last_of_run 0). Character 0 gives a single release report.
// The input register refills while a report waits in the output register.
module ascii_to_hid_key_typer
   import hidkt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   hidkt_char_if.sink     req,
   hidkt_report_if.source rsp
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_char_ff, in_char_in;
   logic           rel_done_ff, rel_done_in;
   logic [7:0]     prev_key_ff, prev_key_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_mod_ff, out_mod_in;
   logic [7:0]     out_key_ff, out_key_in;
   logic           out_last_ff, out_last_in;

   key_report_type mapped;
   logic           need_rel;
   logic           load_out;
   logic           item_done;
   logic           accept;

   assign mapped    = map_char(in_char_ff);
   assign need_rel  = (mapped.key != USAGE_NONE) && (mapped.key == prev_key_ff) &&
                      !rel_done_ff;
   assign load_out  = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign item_done = load_out && !need_rel;
   assign accept    = req.valid && req.ready;

   assign req.ready         = !in_valid_ff || item_done;
   assign rsp.valid         = out_valid_ff;
   assign rsp.modifier_byte = out_mod_ff;
   assign rsp.key_usage     = out_key_ff;
   assign rsp.last_of_run   = out_last_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_char_in   = in_char_ff;
      rel_done_in  = rel_done_ff;
      prev_key_in  = prev_key_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_mod_in   = out_mod_ff;
      out_key_in   = out_key_ff;
      out_last_in  = out_last_ff;

      if (load_out) begin
         out_valid_in = 1'b1;
         if (need_rel) begin
            // insert release, hold the character for its own report
            out_mod_in  = MOD_NONE;
            out_key_in  = USAGE_NONE;
            out_last_in = 1'b0;
            rel_done_in = 1'b1;
         end else begin
            out_mod_in  = mapped.modifier;
            out_key_in  = mapped.key;
            out_last_in = 1'b1;
            prev_key_in = mapped.key;
            in_valid_in = 1'b0;
            rel_done_in = 1'b0;
         end
      end

      if (accept) begin
         in_valid_in = 1'b1;
         in_char_in  = req.char_code;
         rel_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rel_done_ff  <= 1'b0;
         prev_key_ff  <= USAGE_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rel_done_ff  <= rel_done_in;
         prev_key_ff  <= prev_key_in;
         out_valid_ff <= out_valid_in;
      end
      in_char_ff  <= in_char_in;
      out_mod_ff  <= out_mod_in;
      out_key_ff  <= out_key_in;
      out_last_ff <= out_last_in;
   end

   a_rel_holds_char: assert property (@(posedge clock) disable iff (reset)
      load_out && need_rel |=> in_valid_ff && rel_done_ff && $stable(in_char_ff))
      else $error("release did not hold the character in the input register");

   a_prev_key_tracks: assert property (@(posedge clock) disable iff (reset)
      item_done |=> prev_key_ff == $past(mapped.key))
      else $error("previous key not updated from the final report");

   a_rel_done_owned: assert property (@(posedge clock) disable iff (reset)
      rel_done_ff |-> in_valid_ff)
      else $error("release flag set with empty input register");

   a_no_repeat_out: assert property (@(posedge clock) disable iff (reset)
      load_out && out_last_in && out_key_in != USAGE_NONE |-> $past(1'b1) &&
      (rel_done_ff || out_key_in != prev_key_ff))
      else $error("repeated key emitted without a release");

endmodule

### test/hidkt_tb_pkg.sv
// Scoreboard for the ASCII to HID key typer testbench: predicts the HID reports
// for each accepted character and checks the reports that come back.
// Depends on hidkt_pkg.

package hidkt_tb_pkg;
   import hidkt_pkg::*;

   typedef struct packed {
      logic [7:0] modifier;
      logic [7:0] key;
      logic       last_of_run;
   } due_report_type;

   class key_report_scoreboard;
      logic [7:0]     held_key;
      due_report_type due_reports[$];
      int             error_count;

      function new();
         held_key    = USAGE_NONE;
         error_count = 0;
      endfunction

      function key_report_type char_to_report(logic [7:0] c);
         key_report_type r;
         logic           shifted;
         r.key   = USAGE_NONE;
         shifted = 1'b0;
         if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
            shifted = 1'b1;
            r.key   = USAGE_A + (c - CHAR_UPPER_LO);
         end else if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) begin
            r.key = USAGE_A + (c - CHAR_LOWER_LO);
         end else if (c >= 8'h31 && c <= 8'h39) begin
            // digits one through nine sit on usages 30..38
            r.key = 8'd30 + (c - 8'h31);
         end else begin
            // US layout punctuation; quote, apostrophe, slash and question mark stay 0
            case (c)
               CHAR_TAB:        r.key = USAGE_TAB;
               CHAR_NEWLINE:    r.key = USAGE_ENTER;
               CHAR_UNDERSCORE: begin r.key = USAGE_MINUS; shifted = 1'b1; end
               8'h20:           r.key = USAGE_SPACE;
               8'h21:           begin r.key = 8'd30; shifted = 1'b1; end
               8'h23:           begin r.key = 8'd32; shifted = 1'b1; end
               8'h24:           begin r.key = 8'd33; shifted = 1'b1; end
               8'h25:           begin r.key = 8'd34; shifted = 1'b1; end
               8'h26:           begin r.key = 8'd36; shifted = 1'b1; end
               8'h28:           begin r.key = 8'd38; shifted = 1'b1; end
               8'h29:           begin r.key = 8'd39; shifted = 1'b1; end
               8'h2A:           begin r.key = 8'd37; shifted = 1'b1; end
               8'h2B:           begin r.key = USAGE_EQUAL; shifted = 1'b1; end
               8'h2C:           r.key = 8'd54;
               8'h2D:           r.key = USAGE_MINUS;
               8'h2E:           r.key = 8'd55;
               8'h30:           r.key = 8'd39;
               8'h3A:           begin r.key = 8'd51; shifted = 1'b1; end
               8'h3B:           r.key = 8'd51;
               8'h3C:           begin r.key = 8'd54; shifted = 1'b1; end
               8'h3D:           r.key = USAGE_EQUAL;
               8'h3E:           begin r.key = 8'd55; shifted = 1'b1; end
               8'h40:           begin r.key = 8'd31; shifted = 1'b1; end
               default:         r.key = USAGE_NONE;
            endcase
         end
         r.modifier = shifted ? MOD_LSHIFT : MOD_NONE;
         return r;
      endfunction

      function void note_char(logic [7:0] c);
         key_report_type r;
         due_report_type d;
         d.modifier    = MOD_NONE;
         d.key         = USAGE_NONE;
         d.last_of_run = 1'b1;
         if (c == 8'h00) begin
            // end of string: a lone release
            held_key = USAGE_NONE;
            due_reports.push_back(d);
            return;
         end
         r = char_to_report(c);
         if (r.key != USAGE_NONE && r.key == held_key) begin
            d.last_of_run = 1'b0;
            due_reports.push_back(d);
         end
         d.modifier    = r.modifier;
         d.key         = r.key;
         d.last_of_run = 1'b1;
         due_reports.push_back(d);
         held_key = r.key;
      endfunction

      function void check_report(logic [7:0] modifier_byte, logic [7:0] key_usage,
                                 logic last_of_run);
         due_report_type want;
         if (due_reports.size() == 0) begin
            $error("unexpected report: modifier_byte %0h key_usage %0d last_of_run %0b",
                   modifier_byte, key_usage, last_of_run);
            error_count++;
            return;
         end
         want = due_reports.pop_front();
         if (modifier_byte !== want.modifier) begin
            $error("modifier_byte: expected %0h, actual %0h", want.modifier, modifier_byte);
            error_count++;
         end
         if (key_usage !== want.key) begin
            $error("key_usage: expected %0d, actual %0d", want.key, key_usage);
            error_count++;
         end
         if (last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run, last_of_run);
            error_count++;
         end
      endfunction

      function void check_drained();
         if (due_reports.size() != 0) begin
            $error("%0d reports never arrived", due_reports.size());
            error_count++;
         end
      endfunction
   endclass

endpackage

### test/tb_top.sv
// Top-level testbench for ascii_to_hid_key_typer: drives characters, stalls the
// report channel at random and checks every report against the scoreboard.
// Depends on hidkt_pkg, hidkt_if.sv and hidkt_tb_pkg.

module tb_top;
   import hidkt_pkg::*;
   import hidkt_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_CHARS_PER_PHASE = 267;
   localparam int DRAIN_LIMIT = 2000;

   // extremes, every character class, repeats and end of string
   localparam logic [7:0] OPENING_TEXT [25] = '{
      8'h41, 8'h5A, 8'h61, 8'h7A, 8'h61, 8'h41, 8'h20, 8'h40, 8'h22, 8'h27,
      8'h2F, 8'h3F, 8'h0A, 8'h0A, 8'h09, 8'h5F, 8'h2D, 8'h3A, 8'h3B, 8'h00,
      8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF
   };

   logic clock;
   logic reset;
   int   src_idle_pct = 26;
   int   snk_idle_pct = 50;

   hidkt_char_if   req_ch ();
   hidkt_report_if rsp_ch ();

   key_report_scoreboard typist = new();

   ascii_to_hid_key_typer u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         typist.check_report(rsp_ch.modifier_byte, rsp_ch.key_usage, rsp_ch.last_of_run);
      end
   end

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      do @(posedge clock); while (!req_ch.ready);
      typist.note_char(c);
   endtask

   // mostly text with plenty of repeated keys, some raw bytes
   function automatic logic [7:0] pick_char(logic [7:0] prior);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         return prior;
      end else if (pick < 35) begin
         // swap case: same key, other modifier
         if ((prior >= CHAR_UPPER_LO && prior <= CHAR_UPPER_HI) ||
             (prior >= CHAR_LOWER_LO && prior <= CHAR_LOWER_HI)) begin
            return prior ^ 8'h20;
         end
         return 8'($urandom_range(CHAR_PUNCT_LO, CHAR_PUNCT_HI));
      end else if (pick < 42) begin
         return 8'h00;
      end else if (pick < 75) begin
         return 8'($urandom_range(8'h20, 8'h7A));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      logic [7:0] c;
      int         waited;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_TEXT[i]) begin
         send_char(OPENING_TEXT[i]);
      end

      c = 8'h61;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin src_idle_pct = 26; snk_idle_pct = 50; end
            1:       begin src_idle_pct = 50; snk_idle_pct = 26; end
            default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
         endcase
         repeat (RANDOM_CHARS_PER_PHASE) begin
            c = pick_char(c);
            send_char(c);
         end
      end
      req_ch.valid <= 1'b0;

      waited = 0;
      while (typist.due_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      typist.check_drained();

      if (typist.error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
